FILE: rtl/core/iel_pkg.sv
// iel_pkg: shared types, codes and field widths of the insertable element list
// no dependencies; imported by iel_cell and insertable_element_list
package iel_pkg;

    // field widths
    localparam int ELEM_W    = 64;
    localparam int OP_W      = 2;
    localparam int POS_W     = 7;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STAT_W    = 2;

    // default list depth and read-out limit
    localparam int DEF_CAPACITY = 64;
    localparam int MAX_RESULTS  = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd3;

    // per-cycle command broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD     = 2'd0,
        CELL_SHIFT_IN = 2'd1,
        CELL_ROTATE   = 2'd2
    } t_cell_op;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

FILE: rtl/core/iel_cell.sv
// iel_cell: one storage cell of the element chain
// depends on iel_pkg
module iel_cell
    import iel_pkg::*;
#(
    parameter int IDX = 0,
    parameter int XW  = 8
) (
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [XW-1:0]     i_pos,
    input  logic [XW-1:0]     i_ref,
    input  logic [ELEM_W-1:0] i_bcast,
    input  logic [ELEM_W-1:0] i_left,
    input  logic [ELEM_W-1:0] i_right,
    output logic [ELEM_W-1:0] o_data
);

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic [ELEM_W-1:0] r_data;
    logic [ELEM_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_SHIFT_IN: begin
                // make room above the insert point, take the new word at it
                if (MY_IDX == i_pos) begin
                    n_data = i_bcast;
                end else if (MY_IDX > i_pos && MY_IDX <= i_ref) begin
                    n_data = i_left;
                end
            end
            CELL_ROTATE: begin
                // move one place down, head word wraps to the top cell
                if (MY_IDX < i_ref) begin
                    n_data = i_right;
                end else if (MY_IDX == i_ref) begin
                    n_data = i_bcast;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/core/insertable_element_list.sv
// insertable_element_list: ordered list of 64-bit words held in a chain of cells
// depends on iel_pkg and iel_cell
//
//  channel  direction  handshake                payload
//  in       sink       i_in_valid / o_in_ready  i_operation, i_position, i_value
//  out      source     o_out_valid / i_out_ready o_element, o_element_index,
//                                               o_count_now, o_status, o_last
//
// append and insert shift the chain in parallel: the cell at the insert point
// loads the broadcast word, the cells above it their lower neighbour; remove
// only drops the last element. one transfer in per cycle while idle and the
// output register drains. read-out gives one result per element, up to the
// result limit, and takes no input until done; the chain rotates once per
// result and is back in order after the last one. reset clears the count, the
// sequencer and the output valid flag; cells and result payload hold no reset.
// a stalled output holds register and chain, refusing input until it is taken.
module insertable_element_list
    import iel_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [POS_W-1:0]     i_position,
    input  logic [ELEM_W-1:0]    i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ELEM_W-1:0]    o_element,
    output logic [IDX_OUT_W-1:0] o_element_index,
    output logic [CNT_OUT_W-1:0] o_count_now,
    output logic [STAT_W-1:0]    o_status,
    output logic                 o_last
);

    // count width and a common compare width for count, position and cell index
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // chain of cells
    logic [ELEM_W-1:0] cell_data [CAPACITY];
    t_cell_op          cell_op;
    logic [XW-1:0]     cell_pos;
    logic [XW-1:0]     cell_ref;
    logic [ELEM_W-1:0] cell_bcast;

    // control and output registers
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IDX_OUT_W-1:0] r_rd_idx, n_rd_idx;
    logic                r_out_valid;
    logic [ELEM_W-1:0]   r_element, n_element;
    logic [IDX_OUT_W-1:0] r_elem_idx, n_elem_idx;
    logic [CNT_OUT_W-1:0] r_count_now, n_count_now;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_last, n_last;

    logic          slot_free;
    logic          accept;
    logic          load_out;
    logic [XW-1:0] count_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] n_count_x;
    logic [XW-1:0] read_len;
    logic [XW-1:0] rot_top;
    logic          rd_last;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_W-1:0] left_w;
            logic [ELEM_W-1:0] right_w;
            if (g == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            iel_cell #(
                .IDX (g),
                .XW  (XW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op),
                .i_pos   (cell_pos),
                .i_ref   (cell_ref),
                .i_bcast (cell_bcast),
                .i_left  (left_w),
                .i_right (right_w),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    assign count_x   = XW'(r_count);
    assign pos_x     = XW'(i_position);

    // read-out covers at most the result limit; only that front part rotates
    assign read_len = (count_x > XW'(MAX_RESULTS)) ? XW'(MAX_RESULTS) : count_x;
    assign rot_top  = read_len - XW'(1);
    assign rd_last  = (XW'(r_rd_idx) == rot_top);

    // output register can take a result when empty or being drained
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        load_out    = 1'b0;
        n_element   = '0;
        n_elem_idx  = '0;
        n_status    = ST_OK;
        n_last      = 1'b1;
        cell_op     = CELL_HOLD;
        cell_pos    = pos_x;
        cell_ref    = count_x;
        cell_bcast  = i_value;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load_out = 1'b1;
                    case (i_operation)
                        OP_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // results come from the read sequence
                                load_out = 1'b0;
                                n_rd_idx = '0;
                                n_state  = S_READ;
                            end
                        end
                        OP_APPEND: begin
                            if (count_x >= XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                // append is an insert at the end
                                cell_op  = CELL_SHIFT_IN;
                                cell_pos = count_x;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (pos_x > count_x) begin
                                n_status = ST_BAD_IDX;
                            end else if (count_x >= XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_op = CELL_SHIFT_IN;
                                n_count = r_count + CW'(1);
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_READ: begin
                if (slot_free) begin
                    // head cell goes out, chain rotates one place
                    load_out   = 1'b1;
                    n_element  = cell_data[0];
                    n_elem_idx = r_rd_idx;
                    n_last     = rd_last;
                    cell_op    = CELL_ROTATE;
                    cell_ref   = rot_top;
                    cell_bcast = cell_data[0];
                    n_rd_idx   = r_rd_idx + IDX_OUT_W'(1);
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_count_x   = XW'(n_count);
        n_count_now = n_count_x[CNT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_element   <= n_element;
            r_elem_idx  <= n_elem_idx;
            r_count_now <= n_count_now;
            r_status    <= n_status;
            r_last      <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element       = r_element;
    assign o_element_index = r_elem_idx;
    assign o_count_now     = r_count_now;
    assign o_status        = r_status;
    assign o_last          = r_last;

endmodule
